>>> rtl/smpm_pkg.sv
// Shared types, constants and codes for the stereo mixdown peak meter.
package smpm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int METER_COUNT = 4;
    localparam int METER_IDX_BITS = $clog2(METER_COUNT);
    localparam int MODE_BITS = 3;
    localparam int COUNT_BITS = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SAMPLE_BITS-1:0] level_t;
    typedef level_t [METER_COUNT-1:0] level_arr_t;
    typedef logic [METER_IDX_BITS-1:0] meter_idx_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_FOUR_CH   = 3'd0,
        MODE_THREE_CH  = 3'd1,
        MODE_TWO_AVG   = 3'd2,
        MODE_TWO_DIFF  = 3'd3,
        MODE_ONE_DIFF  = 3'd4
    } mode_t;

    localparam meter_idx_t METER_ZERO  = 2'd0;
    localparam meter_idx_t METER_ONE   = 2'd1;
    localparam meter_idx_t METER_TWO   = 2'd2;
    localparam meter_idx_t METER_THREE = 2'd3;

    // Which meter a lane feeds, if any
    typedef struct packed {
        logic       en;
        meter_idx_t idx;
    } meter_sel_t;

    // Everything the first stage decides about one frame
    typedef struct packed {
        count_t     count;
        sample_t    first;
        sample_t    second;
        logic       clear;
        meter_sel_t sel_first;
        meter_sel_t sel_second;
    } frame_plan_t;

    typedef struct packed {
        meter_sel_t sel;
        sample_t    value;
    } lane_req_t;

    typedef struct packed {
        logic       hit;
        meter_idx_t idx;
        level_t     mag;
    } lane_res_t;

endpackage

>>> rtl/smpm_if.sv
// Frame, result and configuration channels of the stereo mixdown peak meter.
interface smpm_frame_if;
    logic                  valid;
    logic                  ready;
    logic                  stream_select;
    smpm_pkg::sample_t     left_sample;
    smpm_pkg::sample_t     right_sample;
    logic                  clear_peaks;

    modport source (output valid, output stream_select, output left_sample,
                    output right_sample, output clear_peaks, input ready);
    modport sink (input valid, input stream_select, input left_sample,
                  input right_sample, input clear_peaks, output ready);
endinterface

interface smpm_result_if;
    logic                  valid;
    logic                  ready;
    smpm_pkg::count_t      mixed_count;
    smpm_pkg::sample_t     mixed_first;
    smpm_pkg::sample_t     mixed_second;
    smpm_pkg::level_t      peak_zero;
    smpm_pkg::level_t      peak_one;
    smpm_pkg::level_t      peak_two;
    smpm_pkg::level_t      peak_three;

    modport source (output valid, output mixed_count, output mixed_first,
                    output mixed_second, output peak_zero, output peak_one,
                    output peak_two, output peak_three, input ready);
    modport sink (input valid, input mixed_count, input mixed_first,
                  input mixed_second, input peak_zero, input peak_one,
                  input peak_two, input peak_three, output ready);
endinterface

interface smpm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [smpm_pkg::MODE_BITS-1:0]      channel_mode;

    modport source (output valid, output channel_mode, input ready);
    modport sink (input valid, input channel_mode, output ready);
endinterface

>>> rtl/smpm_mix.sv
// Frame mixer: forms difference or average and routes the samples to meters.
module smpm_mix
(
    input  smpm_pkg::mode_t       mode,
    input  logic                  stream_select,
    input  smpm_pkg::sample_t     left_sample,
    input  smpm_pkg::sample_t     right_sample,
    input  logic                  clear_peaks,
    output smpm_pkg::frame_plan_t plan
);

    logic signed [smpm_pkg::SAMPLE_BITS:0] sum;
    logic signed [smpm_pkg::SAMPLE_BITS:0] dif;
    logic signed [smpm_pkg::SAMPLE_BITS:0] sum_half;
    logic signed [smpm_pkg::SAMPLE_BITS:0] dif_half;
    smpm_pkg::sample_t                     avg;
    smpm_pkg::sample_t                     diff;

    assign sum = {left_sample[smpm_pkg::SAMPLE_BITS-1], left_sample}
               + {right_sample[smpm_pkg::SAMPLE_BITS-1], right_sample};
    assign dif = {left_sample[smpm_pkg::SAMPLE_BITS-1], left_sample}
               - {right_sample[smpm_pkg::SAMPLE_BITS-1], right_sample};

    // Halve toward zero: floor shift, then bump odd negatives up by one
    assign sum_half = (sum >>> 1)
        + {{smpm_pkg::SAMPLE_BITS{1'b0}}, sum[smpm_pkg::SAMPLE_BITS] & sum[0]};
    assign dif_half = (dif >>> 1)
        + {{smpm_pkg::SAMPLE_BITS{1'b0}}, dif[smpm_pkg::SAMPLE_BITS] & dif[0]};

    assign avg  = sum_half[smpm_pkg::SAMPLE_BITS-1:0];
    assign diff = dif_half[smpm_pkg::SAMPLE_BITS-1:0];

    always_comb
    begin
        plan                = '0;
        plan.clear          = clear_peaks;
        case (mode)
            smpm_pkg::MODE_FOUR_CH:
            begin
                plan.count          = 2'd2;
                plan.first          = left_sample;
                plan.second         = right_sample;
                plan.sel_first.en   = 1'b1;
                plan.sel_first.idx  = stream_select ? smpm_pkg::METER_TWO
                                                    : smpm_pkg::METER_ZERO;
                plan.sel_second.en  = 1'b1;
                plan.sel_second.idx = stream_select ? smpm_pkg::METER_THREE
                                                    : smpm_pkg::METER_ONE;
            end
            smpm_pkg::MODE_THREE_CH:
            begin
                plan.sel_first.en = 1'b1;
                if (stream_select)
                begin
                    plan.count          = 2'd1;
                    plan.first          = diff;
                    plan.sel_first.idx  = smpm_pkg::METER_TWO;
                end
                else
                begin
                    plan.count          = 2'd2;
                    plan.first          = left_sample;
                    plan.second         = right_sample;
                    plan.sel_first.idx  = smpm_pkg::METER_ZERO;
                    plan.sel_second.en  = 1'b1;
                    plan.sel_second.idx = smpm_pkg::METER_ONE;
                end
            end
            smpm_pkg::MODE_TWO_AVG:
            begin
                plan.count         = 2'd1;
                plan.first         = avg;
                plan.sel_first.en  = 1'b1;
                plan.sel_first.idx = stream_select ? smpm_pkg::METER_ONE
                                                   : smpm_pkg::METER_ZERO;
            end
            smpm_pkg::MODE_TWO_DIFF:
            begin
                plan.count         = 2'd1;
                plan.first         = diff;
                plan.sel_first.en  = 1'b1;
                plan.sel_first.idx = stream_select ? smpm_pkg::METER_ONE
                                                   : smpm_pkg::METER_ZERO;
            end
            smpm_pkg::MODE_ONE_DIFF:
            begin
                // Aux frames carry no samples and feed no meter
                if (stream_select)
                begin
                    plan.count         = 2'd1;
                    plan.first         = diff;
                    plan.sel_first.en  = 1'b1;
                    plan.sel_first.idx = smpm_pkg::METER_ZERO;
                end
            end
            default:
            begin
                plan.count = 2'd0;
            end
        endcase
    end

endmodule

>>> rtl/smpm_lane.sv
// Meter lane: magnitude of one sample and compare against its target meter.
module smpm_lane
(
    input  smpm_pkg::lane_req_t  req,
    input  smpm_pkg::level_arr_t base_levels,
    output smpm_pkg::lane_res_t  res
);

    smpm_pkg::level_t mag;

    // Two's complement negate; the most negative sample lands on 2^(N-1)
    assign mag = req.value[smpm_pkg::SAMPLE_BITS-1]
               ? smpm_pkg::level_t'(~req.value) + smpm_pkg::level_t'(1)
               : smpm_pkg::level_t'(req.value);

    assign res.mag = mag;
    assign res.idx = req.sel.idx;
    assign res.hit = req.sel.en && (mag > base_levels[req.sel.idx]);

endmodule

>>> rtl/smpm_merge.sv
// Peak store: applies the clear and merges lane winners into the four meters.
module smpm_merge
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 update,
    input  logic                 clear,
    input  smpm_pkg::lane_res_t  res_first,
    input  smpm_pkg::lane_res_t  res_second,
    output smpm_pkg::level_arr_t base_levels,
    output smpm_pkg::level_arr_t peak_levels
);

    smpm_pkg::level_arr_t peak_reg;
    smpm_pkg::level_arr_t peak_next;

    assign base_levels = clear ? '0 : peak_reg;
    assign peak_levels = peak_reg;

    // Lanes never aim at the same meter within one frame
    always_comb
    begin
        peak_next = peak_reg;
        if (update)
        begin
            for (int m = 0; m < smpm_pkg::METER_COUNT; m++)
            begin
                if (res_first.hit && res_first.idx == smpm_pkg::meter_idx_t'(m))
                begin
                    peak_next[m] = res_first.mag;
                end
                else if (res_second.hit
                         && res_second.idx == smpm_pkg::meter_idx_t'(m))
                begin
                    peak_next[m] = res_second.mag;
                end
                else
                begin
                    peak_next[m] = base_levels[m];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
        end
        else
        begin
            peak_reg <= peak_next;
        end
    end

endmodule

>>> rtl/stereo_mixdown_peak_meter.sv
// Top level: mode register, two-stage frame pipeline, meter lanes and result register.
// Takes one stereo frame per clock while the result side is not stalled and returns one
// result per frame, through the mixing stage and then the result register; a stalled
// result holds one frame in the mixing stage and one in the result register before the
// frame channel stops. The first stage forms the difference or average and picks the
// target meters from channel_mode; the second stage runs two meter lanes (magnitude and
// compare) side by side and merges their winners into the four peak meters, which is the
// loop that limits the rate to one frame per cycle. The peak fields of a result are the
// meters after that frame. channel_mode is written over the cfg channel, which is always
// ready; write it only while no frame is in flight.
module stereo_mixdown_peak_meter
(
    input  logic       clk,
    input  logic       rst_n,
    smpm_frame_if.sink   frame,
    smpm_cfg_if.sink     cfg,
    smpm_result_if.source result
);

    smpm_pkg::mode_t       mode_reg;
    smpm_pkg::mode_t       mode_next;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    smpm_pkg::frame_plan_t s1_plan_reg;
    smpm_pkg::frame_plan_t plan;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    smpm_pkg::count_t      out_count_reg;
    smpm_pkg::sample_t     out_first_reg;
    smpm_pkg::sample_t     out_second_reg;

    logic                  frame_accept;
    logic                  out_can_load;
    logic                  s1_advance;

    smpm_pkg::lane_req_t   req_first;
    smpm_pkg::lane_req_t   req_second;
    smpm_pkg::lane_res_t   res_first;
    smpm_pkg::lane_res_t   res_second;
    smpm_pkg::level_arr_t  base_levels;
    smpm_pkg::level_arr_t  peak_levels;

    assign cfg.ready = 1'b1;

    assign out_can_load = !out_valid_reg || result.ready;
    assign s1_advance   = s1_valid_reg && out_can_load;
    assign frame.ready  = !s1_valid_reg || out_can_load;
    assign frame_accept = frame.valid && frame.ready;

    always_comb
    begin
        mode_next = mode_reg;
        if (cfg.valid && cfg.ready)
        begin
            mode_next = smpm_pkg::mode_t'(cfg.channel_mode);
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (frame_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= smpm_pkg::MODE_FOUR_CH;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    smpm_mix u_mix
    (
        .mode          (mode_reg),
        .stream_select (frame.stream_select),
        .left_sample   (frame.left_sample),
        .right_sample  (frame.right_sample),
        .clear_peaks   (frame.clear_peaks),
        .plan          (plan)
    );

    always_ff @(posedge clk)
    begin
        if (frame_accept)
        begin
            s1_plan_reg <= plan;
        end
        if (s1_advance)
        begin
            out_count_reg  <= s1_plan_reg.count;
            out_first_reg  <= s1_plan_reg.first;
            out_second_reg <= s1_plan_reg.second;
        end
    end

    assign req_first.sel    = s1_plan_reg.sel_first;
    assign req_first.value  = s1_plan_reg.first;
    assign req_second.sel   = s1_plan_reg.sel_second;
    assign req_second.value = s1_plan_reg.second;

    smpm_lane u_lane_first
    (
        .req         (req_first),
        .base_levels (base_levels),
        .res         (res_first)
    );

    smpm_lane u_lane_second
    (
        .req         (req_second),
        .base_levels (base_levels),
        .res         (res_second)
    );

    // Meters move exactly when the frame moves into the result register
    smpm_merge u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (s1_advance),
        .clear       (s1_plan_reg.clear),
        .res_first   (res_first),
        .res_second  (res_second),
        .base_levels (base_levels),
        .peak_levels (peak_levels)
    );

    assign result.valid        = out_valid_reg;
    assign result.mixed_count  = out_count_reg;
    assign result.mixed_first  = out_first_reg;
    assign result.mixed_second = out_second_reg;
    assign result.peak_zero    = peak_levels[smpm_pkg::METER_ZERO];
    assign result.peak_one     = peak_levels[smpm_pkg::METER_ONE];
    assign result.peak_two     = peak_levels[smpm_pkg::METER_TWO];
    assign result.peak_three   = peak_levels[smpm_pkg::METER_THREE];

    a_meters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> $stable(peak_levels))
        else $error("peak meters changed without a frame moving to the result");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        frame_accept |=> s1_valid_reg)
        else $error("accepted frame missing from the mixing stage");

    a_second_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.mixed_count != 2'd2 |-> result.mixed_second == '0)
        else $error("second sample not zero when fewer than two are valid");

    a_lanes_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_plan_reg.sel_first.en && s1_plan_reg.sel_second.en
        |-> s1_plan_reg.sel_first.idx != s1_plan_reg.sel_second.idx)
        else $error("both lanes target the same meter");

endmodule

>>> dv/stereo_mixdown_peak_meter_tb.sv
// Self-checking testbench for the stereo mixdown peak meter: mixing, meters and handshakes.
module stereo_mixdown_peak_meter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic STREAM_AUX  = 1'b0;
    localparam logic STREAM_MANE = 1'b1;

    // Mode codes with no defined mixing
    localparam logic [smpm_pkg::MODE_BITS-1:0] MODE_RSVD_5 = 3'd5;
    localparam logic [smpm_pkg::MODE_BITS-1:0] MODE_RSVD_6 = 3'd6;
    localparam logic [smpm_pkg::MODE_BITS-1:0] MODE_RSVD_7 = 3'd7;

    localparam smpm_pkg::sample_t SAMPLE_MAX = 24'sh7FFFFF;
    localparam smpm_pkg::sample_t SAMPLE_MIN = 24'sh800000;

    typedef struct packed {
        logic              mane;
        smpm_pkg::sample_t left;
        smpm_pkg::sample_t right;
        logic              clear;
    } frame_req_t;

    typedef struct packed {
        smpm_pkg::count_t     count;
        smpm_pkg::sample_t    first;
        smpm_pkg::sample_t    second;
        smpm_pkg::level_arr_t peaks;
    } mix_result_t;

    logic clk = 1'b0;
    logic rst_n;

    smpm_frame_if  frame_ch ();
    smpm_cfg_if    cfg_ch ();
    smpm_result_if result_ch ();

    stereo_mixdown_peak_meter dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    logic [smpm_pkg::MODE_BITS-1:0] mode_cfg = smpm_pkg::MODE_FOUR_CH;
    smpm_pkg::level_arr_t           meter_peaks = '0;
    mix_result_t                    expected_mixes[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_left = 0;
    int error_count = 0;
    int frames_sent = 0;
    int results_checked = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void bump_meter(smpm_pkg::meter_idx_t idx, longint v);
        longint a;
        a = (v < 0) ? -v : v;
        if (a > meter_peaks[idx])
            meter_peaks[idx] = a[smpm_pkg::SAMPLE_BITS-1:0];
    endfunction

    function automatic mix_result_t predict_mix(frame_req_t f);
        mix_result_t r;
        longint lv;
        longint rv;
        longint diff;
        longint avg;
        lv = longint'(f.left);
        rv = longint'(f.right);
        diff = (lv - rv) / 2;
        avg = (lv + rv) / 2;
        r.count = '0;
        r.first = '0;
        r.second = '0;
        if (f.clear)
            meter_peaks = '0;
        case (mode_cfg)
            smpm_pkg::MODE_FOUR_CH:
            begin
                r.count = 2'd2;
                r.first = f.left;
                r.second = f.right;
                bump_meter(f.mane ? smpm_pkg::METER_TWO : smpm_pkg::METER_ZERO, lv);
                bump_meter(f.mane ? smpm_pkg::METER_THREE : smpm_pkg::METER_ONE, rv);
            end
            smpm_pkg::MODE_THREE_CH:
            begin
                if (!f.mane)
                begin
                    r.count = 2'd2;
                    r.first = f.left;
                    r.second = f.right;
                    bump_meter(smpm_pkg::METER_ZERO, lv);
                    bump_meter(smpm_pkg::METER_ONE, rv);
                end
                else
                begin
                    r.count = 2'd1;
                    r.first = diff[smpm_pkg::SAMPLE_BITS-1:0];
                    bump_meter(smpm_pkg::METER_TWO, diff);
                end
            end
            smpm_pkg::MODE_TWO_AVG:
            begin
                r.count = 2'd1;
                r.first = avg[smpm_pkg::SAMPLE_BITS-1:0];
                bump_meter(f.mane ? smpm_pkg::METER_ONE : smpm_pkg::METER_ZERO, avg);
            end
            smpm_pkg::MODE_TWO_DIFF:
            begin
                r.count = 2'd1;
                r.first = diff[smpm_pkg::SAMPLE_BITS-1:0];
                bump_meter(f.mane ? smpm_pkg::METER_ONE : smpm_pkg::METER_ZERO, diff);
            end
            smpm_pkg::MODE_ONE_DIFF:
            begin
                if (f.mane)
                begin
                    r.count = 2'd1;
                    r.first = diff[smpm_pkg::SAMPLE_BITS-1:0];
                    bump_meter(smpm_pkg::METER_ZERO, diff);
                end
            end
            default:
            begin
            end
        endcase
        r.peaks = meter_peaks;
        return r;
    endfunction

    function automatic smpm_pkg::sample_t rand_sample();
        smpm_pkg::sample_t s;
        case ($urandom_range(3))
            0: s = smpm_pkg::sample_t'($urandom);
            1: s = smpm_pkg::sample_t'(int'($urandom_range(510)) - 255);
            2:
            begin
                case ($urandom_range(4))
                    0: s = SAMPLE_MAX;
                    1: s = SAMPLE_MIN;
                    2: s = '0;
                    3: s = '1;
                    default: s = smpm_pkg::sample_t'(1);
                endcase
            end
            default: s = smpm_pkg::sample_t'($signed($urandom) >>> $urandom_range(31));
        endcase
        return s;
    endfunction

    function automatic frame_req_t rand_frame();
        frame_req_t f;
        f.mane = 1'($urandom_range(1));
        f.left = rand_sample();
        f.right = rand_sample();
        // clear now and then so the meters fall back and regrow
        f.clear = ($urandom_range(15) == 0);
        return f;
    endfunction

    function automatic void check_field(string name, longint exp_val, longint act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    // Result side: stall at random, or hold off for a counted stretch
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_off_left--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        mix_result_t e;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_mixes.size() == 0)
            begin
                $error("unexpected result: count %0d first %0d",
                       result_ch.mixed_count, result_ch.mixed_first);
                error_count++;
            end
            else
            begin
                e = expected_mixes.pop_front();
                results_checked++;
                check_field("mixed_count", longint'(e.count),
                            longint'(result_ch.mixed_count));
                check_field("mixed_first", longint'(e.first),
                            longint'(result_ch.mixed_first));
                check_field("mixed_second", longint'(e.second),
                            longint'(result_ch.mixed_second));
                check_field("peak_zero", longint'(e.peaks[smpm_pkg::METER_ZERO]),
                            longint'(result_ch.peak_zero));
                check_field("peak_one", longint'(e.peaks[smpm_pkg::METER_ONE]),
                            longint'(result_ch.peak_one));
                check_field("peak_two", longint'(e.peaks[smpm_pkg::METER_TWO]),
                            longint'(result_ch.peak_two));
                check_field("peak_three", longint'(e.peaks[smpm_pkg::METER_THREE]),
                            longint'(result_ch.peak_three));
            end
        end
    end

    task automatic send_frame(input frame_req_t f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            frame_ch.valid <= 1'b0;
        end
        @(negedge clk);
        frame_ch.valid <= 1'b1;
        frame_ch.stream_select <= f.mane;
        frame_ch.left_sample <= f.left;
        frame_ch.right_sample <= f.right;
        frame_ch.clear_peaks <= f.clear;
        do
            @(posedge clk);
        while (!frame_ch.ready);
        expected_mixes.push_back(predict_mix(f));
        frames_sent++;
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        frame_ch.valid <= 1'b0;
        while (expected_mixes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic [smpm_pkg::MODE_BITS-1:0] code);
        drain_pipeline();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.channel_mode <= code;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        mode_cfg = code;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_directed();
        write_mode(smpm_pkg::MODE_FOUR_CH);
        send_frame(frame_req_t'{STREAM_AUX, SAMPLE_MAX, SAMPLE_MIN, 1'b0});
        send_frame(frame_req_t'{STREAM_MANE, SAMPLE_MIN, SAMPLE_MAX, 1'b0});
        send_frame(frame_req_t'{STREAM_AUX, smpm_pkg::sample_t'(-1),
                                smpm_pkg::sample_t'(1), 1'b1});

        write_mode(smpm_pkg::MODE_THREE_CH);
        send_frame(frame_req_t'{STREAM_AUX, SAMPLE_MIN, SAMPLE_MIN, 1'b0});
        send_frame(frame_req_t'{STREAM_MANE, SAMPLE_MAX, SAMPLE_MIN, 1'b0});
        // odd negative difference rounds toward zero
        send_frame(frame_req_t'{STREAM_MANE, smpm_pkg::sample_t'(-3),
                                smpm_pkg::sample_t'(0), 1'b0});

        write_mode(smpm_pkg::MODE_TWO_AVG);
        send_frame(frame_req_t'{STREAM_AUX, SAMPLE_MIN, SAMPLE_MIN, 1'b0});
        send_frame(frame_req_t'{STREAM_MANE, SAMPLE_MAX, SAMPLE_MAX, 1'b0});
        send_frame(frame_req_t'{STREAM_AUX, smpm_pkg::sample_t'(-1),
                                smpm_pkg::sample_t'(0), 1'b1});
        send_frame(frame_req_t'{STREAM_MANE, smpm_pkg::sample_t'(3),
                                smpm_pkg::sample_t'(0), 1'b0});

        write_mode(smpm_pkg::MODE_TWO_DIFF);
        send_frame(frame_req_t'{STREAM_AUX, SAMPLE_MAX, SAMPLE_MIN, 1'b0});
        send_frame(frame_req_t'{STREAM_MANE, SAMPLE_MIN, SAMPLE_MAX, 1'b0});
        send_frame(frame_req_t'{STREAM_AUX, smpm_pkg::sample_t'(0),
                                smpm_pkg::sample_t'(1), 1'b0});

        write_mode(smpm_pkg::MODE_ONE_DIFF);
        send_frame(frame_req_t'{STREAM_AUX, smpm_pkg::sample_t'(5),
                                smpm_pkg::sample_t'(6), 1'b0});
        send_frame(frame_req_t'{STREAM_MANE, SAMPLE_MIN, SAMPLE_MAX, 1'b0});
        send_frame(frame_req_t'{STREAM_MANE, smpm_pkg::sample_t'(1),
                                smpm_pkg::sample_t'(0), 1'b1});

        // undefined codes: no samples, meters only cleared
        write_mode(MODE_RSVD_5);
        send_frame(frame_req_t'{STREAM_MANE, SAMPLE_MAX, SAMPLE_MAX, 1'b0});
        write_mode(MODE_RSVD_6);
        send_frame(frame_req_t'{STREAM_AUX, SAMPLE_MIN, SAMPLE_MAX, 1'b1});
        write_mode(MODE_RSVD_7);
        send_frame(frame_req_t'{STREAM_MANE, SAMPLE_MIN, SAMPLE_MIN, 1'b0});
    endtask

    task automatic test_random_traffic();
        int send_pct [4] = '{0, 82, 0, 8};
        int recv_pct [4] = '{0, 0, 82, 8};
        smpm_pkg::mode_t mode_list [5] = '{smpm_pkg::MODE_FOUR_CH,
                                           smpm_pkg::MODE_THREE_CH,
                                           smpm_pkg::MODE_TWO_AVG,
                                           smpm_pkg::MODE_TWO_DIFF,
                                           smpm_pkg::MODE_ONE_DIFF};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_pct[p];
            recv_stall_pct = recv_pct[p];
            foreach (mode_list[m])
            begin
                write_mode(mode_list[m]);
                repeat (50) send_frame(rand_frame());
            end
            write_mode(smpm_pkg::MODE_BITS'($urandom_range(MODE_RSVD_7, MODE_RSVD_5)));
            repeat (4) send_frame(rand_frame());
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_mode(smpm_pkg::MODE_THREE_CH);
        repeat (5)
        begin
            // hold the result side long enough that the frame side stalls
            hold_off_left = 40;
            repeat (20) send_frame(rand_frame());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        frame_ch.valid = 1'b0;
        frame_ch.stream_select = 1'b0;
        frame_ch.left_sample = '0;
        frame_ch.right_sample = '0;
        frame_ch.clear_peaks = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.channel_mode = smpm_pkg::MODE_FOUR_CH;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_traffic();
        test_backpressure();

        drain_pipeline();
        repeat (8) @(posedge clk);
        $display("Covered %0d frames over all eight mode codes, idle and stall phases",
                 frames_sent);
        $display("and result-side hold-offs; %0d results compared, %0d mismatches.",
                 results_checked, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/smpm_pkg.sv
rtl/smpm_if.sv
rtl/smpm_mix.sv
rtl/smpm_lane.sv
rtl/smpm_merge.sv
rtl/stereo_mixdown_peak_meter.sv
dv/stereo_mixdown_peak_meter_tb.sv
